// File: design/byte_stuffing_deframer_top_defines.svh
// assertion macros used by the deframer rtl
// expects clk and rst_n in the scope of every use
`ifndef BYTE_STUFFING_DEFRAMER_TOP_DEFINES_SVH
`define BYTE_STUFFING_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BSD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsd check failed");

// next-cycle implication, checked outside reset
`define BSD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsd check failed");

`endif

// File: design/bsd_pkg.sv
// types, codes and reset values for the byte stuffing deframer
// no dependencies
package bsd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_CODE   = 3'd0,
        CFG_END_CODE     = 3'd1,
        CFG_ESCAPE_CODE  = 3'd2,
        CFG_NULL_CODE    = 3'd3,
        CFG_LENGTH_LIMIT = 3'd4,
        CFG_IDLE_LIMIT   = 3'd5
    } cfg_idx_t;

    localparam logic [7:0]  RST_START_CODE   = 8'hAC;
    localparam logic [7:0]  RST_END_CODE     = 8'hAD;
    localparam logic [7:0]  RST_ESCAPE_CODE  = 8'hAE;
    localparam logic [7:0]  RST_NULL_CODE    = 8'hAF;
    localparam logic [15:0] RST_LENGTH_LIMIT = 16'd65535;
    localparam logic [13:0] RST_IDLE_LIMIT   = 14'd10000;

    localparam logic [7:0] ESCAPE_BIT = 8'h80;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_START = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CLS_DATA   = 3'd0,
        CLS_END    = 3'd1,
        CLS_NULL   = 3'd2,
        CLS_ESCAPE = 3'd3,
        CLS_START  = 3'd4
    } cls_t;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] escape_code;
        logic [7:0] null_code;
    } codes_t;

    typedef struct packed {
        logic [15:0] length_limit;
        logic [13:0] idle_limit;
    } limits_t;

    // one classified byte between front and back
    typedef struct packed {
        cls_t       cls;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] position;
        logic [15:0] frame_length;
        status_t     status;
        logic        last;
    } result_t;

endpackage

// File: design/byte_stuffing_deframer_top.sv
// byte stuffing deframer: a pushed byte passes the front queue, then the result queue, to the ports
// throughput one byte per cycle unless pop stalls; front queue and result queue are two deep each
// a stalled pop backs up the result queue, then the front queue, then raises full
// reset (rst_n low, async): frame state cleared, queues empty, codes and limits
// return to 0xac/0xad/0xae/0xaf, length limit 65535, idle limit 10000
// uses bsd_pkg, bsd_front and bsd_back
module byte_stuffing_deframer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // byte input, queue style
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     rx_byte,
    // result output, queue style
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     payload_byte,
    output logic [15:0]                    position,
    output logic [15:0]                    frame_length,
    output logic [1:0]                     status,
    output logic                           last,
    // register write port
    input  logic                           cfg_wr_en,
    input  logic [bsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bsd_pkg::*;

    // code registers feed the classifier, limits feed the frame logic
    codes_t  codes_reg;
    limits_t limits_reg;

    // word handoff from front to back
    logic    q_valid;
    item_t   q_item;
    logic    q_take;

    // register file; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.start_code    <= RST_START_CODE;
            codes_reg.end_code      <= RST_END_CODE;
            codes_reg.escape_code   <= RST_ESCAPE_CODE;
            codes_reg.null_code     <= RST_NULL_CODE;
            limits_reg.length_limit <= RST_LENGTH_LIMIT;
            limits_reg.idle_limit   <= RST_IDLE_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_CODE:   codes_reg.start_code    <= cfg_data[7:0];
                CFG_END_CODE:     codes_reg.end_code      <= cfg_data[7:0];
                CFG_ESCAPE_CODE:  codes_reg.escape_code   <= cfg_data[7:0];
                CFG_NULL_CODE:    codes_reg.null_code     <= cfg_data[7:0];
                CFG_LENGTH_LIMIT: limits_reg.length_limit <= cfg_data[15:0];
                CFG_IDLE_LIMIT:   limits_reg.idle_limit   <= cfg_data[13:0];
                default:
                begin
                end
            endcase
        end
    end

    // front: classify each accepted byte and queue it
    bsd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .rx_byte (rx_byte),
        .codes   (codes_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take)
    );

    // back: frame state update, one classified word per cycle while the result queue has room
    bsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_take       (q_take),
        .limits       (limits_reg),
        .empty        (empty),
        .pop          (pop),
        .payload_byte (payload_byte),
        .position     (position),
        .frame_length (frame_length),
        .status       (status),
        .last         (last)
    );

endmodule

// File: design/bsd_front.sv
// front end: accepts raw bytes, classifies them against the code registers
// and holds them in a two-entry queue; uses bsd_pkg
module bsd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      rx_byte,
    input  bsd_pkg::codes_t codes,
    output logic            q_valid,
    output bsd_pkg::item_t  q_item,
    input  logic            q_take
);
    import bsd_pkg::*;

    item_t       ent_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push_ok;
    logic        take_ok;
    item_t       new_item;

    // end wins over null, null over escape, escape over start
    always_comb
    begin
        new_item.data = rx_byte;
        if (rx_byte == codes.end_code)
        begin
            new_item.cls = CLS_END;
        end
        else if (rx_byte == codes.null_code)
        begin
            new_item.cls = CLS_NULL;
        end
        else if (rx_byte == codes.escape_code)
        begin
            new_item.cls = CLS_ESCAPE;
        end
        else if (rx_byte == codes.start_code)
        begin
            new_item.cls = CLS_START;
        end
        else
        begin
            new_item.cls = CLS_DATA;
        end
    end

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = ent_reg[rd_ptr_reg];
    assign push_ok = push && !full;
    assign take_ok = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = push_ok ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take_ok ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push_ok} - {1'b0, take_ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            ent_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// File: design/bsd_back.sv
// back end: frame state, result generation and a two-entry result queue
// uses bsd_pkg and the shared assertion macros
`include "byte_stuffing_deframer_top_defines.svh"

module bsd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  bsd_pkg::item_t   q_item,
    output logic             q_take,
    input  bsd_pkg::limits_t limits,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       payload_byte,
    output logic [15:0]      position,
    output logic [15:0]      frame_length,
    output logic [1:0]       status,
    output logic             last
);
    import bsd_pkg::*;

    logic [15:0] wpos_reg;
    logic [15:0] wpos_next;
    logic        start_seen_reg;
    logic        start_seen_next;
    logic        esc_reg;
    logic        esc_next;
    logic [13:0] idle_reg;
    logic [13:0] idle_next;

    result_t     out_reg [2];
    logic        out_wr_ptr_reg;
    logic        out_rd_ptr_reg;
    logic [1:0]  out_cnt_reg;
    logic [1:0]  out_cnt_next;
    logic        pop_ok;
    logic        step;

    logic        res_valid;
    result_t     res;
    logic        fin;
    status_t     fin_status;
    logic [7:0]  data_b;
    result_t     head;

    assign pop_ok = pop && !empty;
    // a step needs room for a result even when the item gives none
    assign step   = q_valid && ((out_cnt_reg != 2'd2) || pop_ok);
    assign q_take = step;
    assign data_b = q_item.data | (esc_reg ? ESCAPE_BIT : 8'h00);

    always_comb
    begin
        wpos_next       = wpos_reg;
        start_seen_next = start_seen_reg;
        esc_next        = esc_reg;
        idle_next       = idle_reg;
        res_valid       = 1'b0;
        res             = '0;
        fin             = 1'b0;
        fin_status      = ST_OK;

        case (q_item.cls)
            CLS_END:
            begin
                fin        = 1'b1;
                fin_status = start_seen_reg ? ST_OK : ST_NO_START;
            end
            CLS_NULL:
            begin
                if (!start_seen_reg)
                begin
                    if (idle_reg >= limits.idle_limit)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_TIMEOUT;
                    end
                    else
                    begin
                        idle_next = idle_reg + 14'd1;
                    end
                end
                else if (idle_reg > limits.idle_limit)
                begin
                    // only after the idle limit was lowered mid-frame
                    fin        = 1'b1;
                    fin_status = ST_TIMEOUT;
                end
            end
            CLS_ESCAPE:
            begin
                esc_next = 1'b1;
            end
            CLS_START:
            begin
                wpos_next       = 16'd0;
                start_seen_next = 1'b1;
            end
            CLS_DATA:
            begin
                esc_next = 1'b0;
                if (wpos_reg >= limits.length_limit)
                begin
                    fin        = 1'b1;
                    fin_status = ST_OVERFLOW;
                end
                else
                begin
                    res_valid        = 1'b1;
                    res.payload_byte = data_b;
                    res.position     = wpos_reg;
                    res.frame_length = wpos_reg + 16'd1;
                    res.status       = ST_OK;
                    res.last         = 1'b0;
                    wpos_next        = wpos_reg + 16'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            res_valid        = 1'b1;
            res              = '0;
            res.frame_length = wpos_reg;
            res.status       = fin_status;
            res.last         = 1'b1;
            wpos_next        = 16'd0;
            start_seen_next  = 1'b0;
            esc_next         = 1'b0;
            idle_next        = 14'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg       <= 16'd0;
            start_seen_reg <= 1'b0;
            esc_reg        <= 1'b0;
            idle_reg       <= 14'd0;
        end
        else if (step)
        begin
            wpos_reg       <= wpos_next;
            start_seen_reg <= start_seen_next;
            esc_reg        <= esc_next;
            idle_reg       <= idle_next;
        end
    end

    // result queue
    always_comb
    begin
        out_cnt_next = out_cnt_reg + {1'b0, step && res_valid} - {1'b0, pop_ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
            out_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (step && res_valid)
            begin
                out_wr_ptr_reg <= !out_wr_ptr_reg;
            end
            if (pop_ok)
            begin
                out_rd_ptr_reg <= !out_rd_ptr_reg;
            end
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_reg[out_wr_ptr_reg] <= res;
        end
    end

    assign head         = out_reg[out_rd_ptr_reg];
    assign empty        = (out_cnt_reg == 2'd0);
    assign payload_byte = head.payload_byte;
    assign position     = head.position;
    assign frame_length = head.frame_length;
    assign status       = head.status;
    assign last         = head.last;

    `BSD_ASSERT_NXT(a_fin_clears, step && res_valid && res.last, (wpos_reg == 16'd0) && !start_seen_reg && !esc_reg && (idle_reg == 14'd0))
    `BSD_ASSERT_IMP(a_data_len, !empty && !last, (frame_length == position + 16'd1) && (status == ST_OK))
    `BSD_ASSERT_IMP(a_fin_zero, !empty && last, (payload_byte == 8'd0) && (position == 16'd0))
    `BSD_ASSERT_IMP(a_no_room, (out_cnt_reg == 2'd2) && !pop, !q_take)

endmodule
